### hw/rtl/xcr_pkg.sv
// ---------------------------------------------------------------------------
// xcr_pkg
// shared types, protocol codes and helpers of the checksum xmodem receiver
// ---------------------------------------------------------------------------
package xcr_pkg;

  localparam int unsigned FrameLen     = 132;
  localparam int unsigned SumLen       = 131;
  localparam int unsigned PayloadOfs   = 3;
  localparam int unsigned WordsOut     = 16;
  localparam int unsigned BytesPerWord = 8;

  localparam logic [7:0] ChSoh      = 8'h01;
  localparam logic [7:0] ChEot      = 8'h04;
  localparam logic [7:0] ChAck      = 8'h06;
  localparam logic [7:0] ChNak      = 8'h15;
  localparam logic [7:0] ChCan      = 8'h18;
  localparam logic [7:0] RetryReset = 8'd10;

  typedef enum logic [1:0] {
    ModeByte  = 2'd0,
    ModeTick  = 2'd1,
    ModeStart = 2'd2
  } mode_e;

  typedef enum logic [1:0] {
    PhRunning = 2'd0,
    PhDone    = 2'd1,
    PhCancel  = 2'd2,
    PhRetries = 2'd3
  } phase_e;

  typedef struct packed {
    logic        tx_valid;
    logic [7:0]  tx_byte;
    logic        data_valid;
    logic [63:0] data_word;
    logic [3:0]  word_index;
    logic        last;
    logic [1:0]  status;
  } xcr_res_t;

  typedef struct packed {
    logic       we;
    logic [7:0] waddr;
    logic [7:0] wdata;
    logic       re;
    logic [7:0] raddr;
  } xcr_ram_req_t;

  // position within the circular frame buffer
  function automatic logic [7:0] wrap_pos(input logic [7:0] base, input logic [7:0] pos);
    logic [8:0] s;
    s = {1'b0, base} + {1'b0, pos};
    if (s >= 9'(FrameLen)) begin
      s = s - 9'(FrameLen);
    end
    return s[7:0];
  endfunction

  // saturating attempt counter
  function automatic logic [7:0] bump_att(input logic [7:0] a);
    logic [7:0] r;
    r = (a == 8'hFF) ? a : a + 8'd1;
    return r;
  endfunction

endpackage

### hw/rtl/xcr_frame_ram.sv
// ---------------------------------------------------------------------------
// xcr_frame_ram
// frame buffer, one write and one registered read port
// ---------------------------------------------------------------------------
module xcr_frame_ram
  import xcr_pkg::*;
(
  input  logic         clk_i,
  input  xcr_ram_req_t req_i,
  output logic [7:0]   rdata_o
);

  logic [7:0] mem_q [FrameLen];
  logic [7:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (req_i.we) begin
      mem_q[req_i.waddr] <= req_i.wdata;
    end
  end

  always_ff @(posedge clk_i) begin
    if (req_i.re) begin
      rdata_q <= mem_q[req_i.raddr];
    end
  end

  assign rdata_o = rdata_q;

endmodule

### hw/rtl/xcr_seq.sv
// ---------------------------------------------------------------------------
// xcr_seq
// protocol sequencer: buffer fill, frame scan, verdict and payload read-out
// ---------------------------------------------------------------------------
module xcr_seq
  import xcr_pkg::*;
(
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         in_valid_i,
  output logic         in_ready_o,
  input  logic [1:0]   in_mode_i,
  input  logic [7:0]   in_byte_i,
  input  logic [7:0]   retry_limit_i,
  output logic         res_valid_o,
  output xcr_res_t     res_o,
  input  logic         res_ready_i,
  output xcr_ram_req_t ram_req_o,
  input  logic [7:0]   ram_rdata_i
);

  typedef enum logic [6:0] {
    S_IDLE   = 7'b0000001,
    S_EXEC   = 7'b0000010,
    S_SCAN   = 7'b0000100,
    S_DECIDE = 7'b0001000,
    S_RESP   = 7'b0010000,
    S_WREAD  = 7'b0100000,
    S_WEMIT  = 7'b1000000
  } state_e;

  state_e      state_q, state_d;
  logic [1:0]  mode_q, mode_d;
  logic [7:0]  byte_q, byte_d;
  logic [7:0]  base_q, base_d;
  logic [7:0]  fill_q, fill_d;
  logic [7:0]  exp_q, exp_d;
  logic [7:0]  att_q, att_d;
  phase_e      phase_q, phase_d;
  logic [7:0]  iss_q, iss_d;
  logic        rdv_q, rdv_d;
  logic [7:0]  rpos_q, rpos_d;
  logic [7:0]  sum_q, sum_d;
  logic [7:0]  b0_q, b0_d;
  logic [7:0]  b1_q, b1_d;
  logic [7:0]  b2_q, b2_d;
  logic [7:0]  ck_q, ck_d;
  logic        found_q, found_d;
  logic [7:0]  soh_q, soh_d;
  logic [3:0]  wk_q, wk_d;
  logic [63:0] word_q, word_d;
  logic        rtxv_q, rtxv_d;
  logic [7:0]  rtxb_q, rtxb_d;
  logic [7:0]  att_n;
  logic [7:0]  rd_pos;
  logic        frame_ok;

  assign att_n    = bump_att(att_q);
  assign frame_ok = (b0_q == ChSoh) && (b2_q == ~b1_q) && (sum_q == ck_q);
  assign rd_pos   = 8'(PayloadOfs) + {1'b0, wk_q, 3'b000} + iss_q;

  always_comb begin
    state_d   = state_q;
    mode_d    = mode_q;
    byte_d    = byte_q;
    base_d    = base_q;
    fill_d    = fill_q;
    exp_d     = exp_q;
    att_d     = att_q;
    phase_d   = phase_q;
    iss_d     = iss_q;
    rdv_d     = 1'b0;
    rpos_d    = rpos_q;
    sum_d     = sum_q;
    b0_d      = b0_q;
    b1_d      = b1_q;
    b2_d      = b2_q;
    ck_d      = ck_q;
    found_d   = found_q;
    soh_d     = soh_q;
    wk_d      = wk_q;
    word_d    = word_q;
    rtxv_d    = rtxv_q;
    rtxb_d    = rtxb_q;
    ram_req_o = '0;
    res_valid_o = 1'b0;
    res_o     = '0;
    in_ready_o = 1'b0;

    unique case (state_q)
      S_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          mode_d  = in_mode_i;
          byte_d  = in_byte_i;
          state_d = S_EXEC;
        end
      end

      S_EXEC: begin
        state_d = S_IDLE;
        if (mode_q == ModeStart) begin
          fill_d  = '0;
          exp_d   = 8'd1;
          att_d   = '0;
          phase_d = PhRunning;
          rtxv_d  = 1'b1;
          rtxb_d  = ChNak;
          state_d = S_RESP;
        end else if (phase_q == PhRunning) begin
          if (mode_q == ModeTick) begin
            att_d  = att_n;
            if (att_n > retry_limit_i) begin
              phase_d = PhRetries;
            end
            rtxv_d  = 1'b1;
            rtxb_d  = ChNak;
            state_d = S_RESP;
          end else if (mode_q == ModeByte) begin
            ram_req_o.we    = 1'b1;
            ram_req_o.waddr = wrap_pos(base_q, fill_q);
            ram_req_o.wdata = byte_q;
            fill_d          = fill_q + 8'd1;
            if (fill_q == '0 && byte_q == ChEot) begin
              phase_d = PhDone;
              rtxv_d  = 1'b1;
              rtxb_d  = ChAck;
              state_d = S_RESP;
            end else if (fill_q == '0 && byte_q == ChCan) begin
              phase_d = PhCancel;
              rtxv_d  = 1'b0;
              rtxb_d  = '0;
              state_d = S_RESP;
            end else if (fill_q == 8'(FrameLen - 1)) begin
              iss_d   = '0;
              sum_d   = '0;
              found_d = 1'b0;
              soh_d   = '0;
              state_d = S_SCAN;
            end
          end
        end
      end

      S_SCAN: begin
        if (iss_q < 8'(FrameLen)) begin
          ram_req_o.re    = 1'b1;
          ram_req_o.raddr = wrap_pos(base_q, iss_q);
          rdv_d           = 1'b1;
          rpos_d          = iss_q;
          iss_d           = iss_q + 8'd1;
        end
        if (rdv_q) begin
          if (rpos_q < 8'(SumLen)) begin
            sum_d = sum_q + ram_rdata_i;
          end
          if (rpos_q == 8'd0) begin
            b0_d = ram_rdata_i;
          end
          if (rpos_q == 8'd1) begin
            b1_d = ram_rdata_i;
          end
          if (rpos_q == 8'd2) begin
            b2_d = ram_rdata_i;
          end
          if (rpos_q == 8'(SumLen)) begin
            ck_d = ram_rdata_i;
          end
          if (rpos_q != 8'd0 && ram_rdata_i == ChSoh && !found_q) begin
            found_d = 1'b1;
            soh_d   = rpos_q;
          end
          if (rpos_q == 8'(FrameLen - 1)) begin
            state_d = S_DECIDE;
          end
        end
      end

      S_DECIDE: begin
        state_d = S_IDLE;
        if (!frame_ok) begin
          // resync to the next start-of-header in the buffer
          if (found_q) begin
            base_d = wrap_pos(base_q, soh_q);
            fill_d = 8'(FrameLen) - soh_q;
          end else begin
            fill_d = '0;
          end
          att_d = att_n;
          if (att_n > retry_limit_i) begin
            phase_d = PhRetries;
            rtxv_d  = 1'b0;
            rtxb_d  = '0;
            state_d = S_RESP;
          end
        end else begin
          fill_d = '0;
          if (b1_q == exp_q - 8'd1) begin
            att_d = 8'd1;
            if (retry_limit_i == '0) begin
              phase_d = PhRetries;
            end
            rtxv_d  = 1'b1;
            rtxb_d  = ChAck;
            state_d = S_RESP;
          end else if (b1_q == exp_q) begin
            exp_d   = exp_q + 8'd1;
            att_d   = '0;
            wk_d    = '0;
            iss_d   = '0;
            state_d = S_WREAD;
          end else begin
            att_d = att_n;
            if (att_n > retry_limit_i) begin
              phase_d = PhRetries;
            end
            rtxv_d  = 1'b1;
            rtxb_d  = ChNak;
            state_d = S_RESP;
          end
        end
      end

      S_RESP: begin
        res_valid_o      = 1'b1;
        res_o.tx_valid   = rtxv_q;
        res_o.tx_byte    = rtxb_q;
        res_o.last       = 1'b1;
        res_o.status     = phase_q;
        if (res_ready_i) begin
          state_d = S_IDLE;
        end
      end

      S_WREAD: begin
        if (iss_q < 8'(BytesPerWord)) begin
          ram_req_o.re    = 1'b1;
          ram_req_o.raddr = wrap_pos(base_q, rd_pos);
          rdv_d           = 1'b1;
          rpos_d          = iss_q;
          iss_d           = iss_q + 8'd1;
        end
        if (rdv_q) begin
          for (int l = 0; l < BytesPerWord; l++) begin
            if (rpos_q[2:0] == 3'(l)) begin
              word_d[l*8 +: 8] = ram_rdata_i;
            end
          end
          if (rpos_q[2:0] == 3'(BytesPerWord - 1)) begin
            state_d = S_WEMIT;
          end
        end
      end

      S_WEMIT: begin
        res_valid_o      = 1'b1;
        res_o.tx_valid   = (wk_q == '0);
        res_o.tx_byte    = (wk_q == '0) ? ChAck : '0;
        res_o.data_valid = 1'b1;
        res_o.data_word  = word_q;
        res_o.word_index = wk_q;
        res_o.last       = (wk_q == 4'(WordsOut - 1));
        res_o.status     = phase_q;
        if (res_ready_i) begin
          if (wk_q == 4'(WordsOut - 1)) begin
            state_d = S_IDLE;
          end else begin
            wk_d    = wk_q + 4'd1;
            iss_d   = '0;
            state_d = S_WREAD;
          end
        end
      end

      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      base_q  <= '0;
      fill_q  <= '0;
      exp_q   <= 8'd1;
      att_q   <= '0;
      phase_q <= PhRunning;
      iss_q   <= '0;
      rdv_q   <= 1'b0;
      found_q <= 1'b0;
      wk_q    <= '0;
    end else begin
      state_q <= state_d;
      base_q  <= base_d;
      fill_q  <= fill_d;
      exp_q   <= exp_d;
      att_q   <= att_d;
      phase_q <= phase_d;
      iss_q   <= iss_d;
      rdv_q   <= rdv_d;
      found_q <= found_d;
      wk_q    <= wk_d;
    end
  end

  always_ff @(posedge clk_i) begin
    mode_q <= mode_d;
    byte_q <= byte_d;
    rpos_q <= rpos_d;
    sum_q  <= sum_d;
    b0_q   <= b0_d;
    b1_q   <= b1_d;
    b2_q   <= b2_d;
    ck_q   <= ck_d;
    soh_q  <= soh_d;
    word_q <= word_d;
    rtxv_q <= rtxv_d;
    rtxb_q <= rtxb_d;
  end

endmodule

### hw/rtl/xmodem_checksum_receiver.sv
// a byte that does not complete a frame is written to the buffer in the exec state;
// a tick, start, eot or can reply passes through the exec and resp states to the output register
// a completed frame is scanned from the buffer memory, then an accepted block
// streams 16 words, each read byte by byte (one buffer read port)
// one item at a time; a result waiting at the output does not block the next item
// reset: transfer running, expected block 1, buffer empty, retry limit 10
// ---------------------------------------------------------------------------
// xmodem_checksum_receiver
// xmodem receiver with 8-bit checksum, 132-byte frames, payload out as words
// ---------------------------------------------------------------------------
module xmodem_checksum_receiver
  import xcr_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_tvalid_i,
  output logic        s_tready_o,
  input  logic [7:0]  s_tdata_i,   // rx_byte
  input  logic [1:0]  s_tuser_i,   // mode
  output logic        m_tvalid_o,
  input  logic        m_tready_i,
  output logic [79:0] m_tdata_o,   // tx_byte, data_word, word_index, status, zero pad
  output logic [1:0]  m_tuser_o,   // tx_valid, data_valid
  output logic        m_tlast_o,
  input  logic        cfg_we_i,
  input  logic [7:0]  cfg_wdata_i
);

  logic         m_valid_q, m_valid_d;
  xcr_res_t     out_q;
  xcr_res_t     res;
  logic         res_valid;
  logic         out_free;
  logic [7:0]   retry_q;
  xcr_ram_req_t ram_req;
  logic [7:0]   ram_rdata;

  assign out_free = !m_valid_q || m_tready_i;

  xcr_seq u_seq (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (s_tvalid_i),
    .in_ready_o    (s_tready_o),
    .in_mode_i     (s_tuser_i),
    .in_byte_i     (s_tdata_i),
    .retry_limit_i (retry_q),
    .res_valid_o   (res_valid),
    .res_o         (res),
    .res_ready_i   (out_free),
    .ram_req_o     (ram_req),
    .ram_rdata_i   (ram_rdata)
  );

  xcr_frame_ram u_ram (
    .clk_i   (clk_i),
    .req_i   (ram_req),
    .rdata_o (ram_rdata)
  );

  always_comb begin
    m_valid_d = m_valid_q;
    if (res_valid && out_free) begin
      m_valid_d = 1'b1;
    end else if (m_tready_i) begin
      m_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      m_valid_q <= 1'b0;
      retry_q   <= RetryReset;
    end else begin
      m_valid_q <= m_valid_d;
      if (cfg_we_i) begin
        retry_q <= cfg_wdata_i;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (res_valid && out_free) begin
      out_q <= res;
    end
  end

  assign m_tvalid_o = m_valid_q;
  assign m_tdata_o  = {2'b00, out_q.status, out_q.word_index, out_q.data_word, out_q.tx_byte};
  assign m_tuser_o  = {out_q.data_valid, out_q.tx_valid};
  assign m_tlast_o  = out_q.last;

  // payload words only leave while the transfer runs
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_tvalid_o && m_tuser_o[1] |-> m_tdata_o[77:76] == PhRunning)
    else $error("data word with finished status");

  // a reply is always ack or nak, otherwise the byte is zero
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_tvalid_o |-> (m_tuser_o[0] && (m_tdata_o[7:0] == ChAck || m_tdata_o[7:0] == ChNak))
                || (!m_tuser_o[0] && m_tdata_o[7:0] == 8'h00))
    else $error("bad reply byte");

  // only the first payload word carries the ack
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_tvalid_o && m_tuser_o[1] && m_tdata_o[75:72] != 4'd0 |-> !m_tuser_o[0])
    else $error("reply on a later payload word");

  // one item in flight: no acceptance in the cycle after one
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_tvalid_i && s_tready_o |=> !s_tready_o)
    else $error("item taken while busy");

endmodule
